// ===== src/icph_pkg.sv =====
// Shared types, register indexes and ones' complement helper for the
// internet checksum pseudo-header unit. No dependencies.
package icph_pkg;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;

  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  localparam cfg_idx_t REG_PSEUDO_ENABLE = cfg_idx_t'(0);
  localparam cfg_idx_t REG_ZERO_ADJUST   = cfg_idx_t'(1);

  // Packet totals handed from the accumulator to the final stage.
  typedef struct packed {
    logic [15:0] sum;
    logic [15:0] byte_count;
    logic [15:0] protocol_word;
  } fin_t;

  typedef struct packed {
    logic pseudo_enable;
    logic zero_adjust;
  } cfg_t;

  // 16-bit add with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ===== src/icph_in_if.sv =====
// Input channel of the checksum unit: one packet byte per word.
// Depends on nothing.
interface icph_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  data_byte;
  logic        last;
  logic [15:0] protocol_word;

  modport source(output valid, func, data_byte, last, protocol_word, input ready);
  modport sink(input valid, func, data_byte, last, protocol_word, output ready);
endinterface

// ===== src/icph_out_if.sv =====
// Result channel of the checksum unit: one checksum per packet.
// Depends on nothing.
interface icph_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] checksum;

  modport source(output valid, checksum, input ready);
  modport sink(input valid, checksum, output ready);
endinterface

// ===== src/icph_cfg_if.sv =====
// Configuration write channel of the checksum unit.
// Depends on icph_pkg for index and data widths.
interface icph_cfg_if;
  logic                valid;
  logic                ready;
  icph_pkg::cfg_idx_t  index;
  icph_pkg::cfg_data_t data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== src/icph_accum.sv =====
// Input register and running ones' complement accumulator; emits the packet
// totals on the last byte. Depends on icph_pkg and icph_in_if.
module icph_accum (
  input  logic           clk,
  input  logic           rst_n,
  icph_in_if.sink        in_ch,
  output logic           fin_valid,
  output icph_pkg::fin_t fin_word,
  input  logic           fin_ready
);
  import icph_pkg::*;

  logic        in_v_r, in_v_nxt;
  logic        in_func_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;
  logic [15:0] in_proto_r;

  logic [15:0] acc_r, acc_nxt;
  logic        pay_odd_r, pay_odd_nxt;
  logic        addr_odd_r, addr_odd_nxt;
  logic [15:0] cnt_r, cnt_nxt;

  logic        fin_v_r, fin_v_nxt;
  fin_t        fin_r;

  logic        take;
  logic        odd;
  logic [15:0] word;
  logic [15:0] acc_sum;
  logic [15:0] cnt_sum;

  // A last byte needs room in the totals register; others never stall.
  assign take        = in_v_r && (!in_last_r || !fin_v_r || fin_ready);
  assign in_ch.ready = !in_v_r || take;

  assign odd     = in_func_r ? addr_odd_r : pay_odd_r;
  assign word    = odd ? {8'h00, in_byte_r} : {in_byte_r, 8'h00};
  assign acc_sum = oc_add(acc_r, word);
  assign cnt_sum = in_func_r ? cnt_r : cnt_r + 16'd1;

  always_comb begin
    in_v_nxt     = in_ch.ready ? in_ch.valid : in_v_r;
    acc_nxt      = acc_r;
    pay_odd_nxt  = pay_odd_r;
    addr_odd_nxt = addr_odd_r;
    cnt_nxt      = cnt_r;
    fin_v_nxt    = fin_v_r && !fin_ready;
    if (take) begin
      if (in_last_r) begin
        acc_nxt      = '0;
        pay_odd_nxt  = 1'b0;
        addr_odd_nxt = 1'b0;
        cnt_nxt      = '0;
        fin_v_nxt    = 1'b1;
      end else begin
        acc_nxt      = acc_sum;
        pay_odd_nxt  = pay_odd_r ^ !in_func_r;
        addr_odd_nxt = addr_odd_r ^ in_func_r;
        cnt_nxt      = cnt_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      acc_r      <= '0;
      pay_odd_r  <= 1'b0;
      addr_odd_r <= 1'b0;
      cnt_r      <= '0;
      fin_v_r    <= 1'b0;
    end else begin
      in_v_r     <= in_v_nxt;
      acc_r      <= acc_nxt;
      pay_odd_r  <= pay_odd_nxt;
      addr_odd_r <= addr_odd_nxt;
      cnt_r      <= cnt_nxt;
      fin_v_r    <= fin_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_func_r  <= in_ch.func;
      in_byte_r  <= in_ch.data_byte;
      in_last_r  <= in_ch.last;
      in_proto_r <= in_ch.protocol_word;
    end
    if (take && in_last_r) begin
      fin_r.sum           <= acc_sum;
      fin_r.byte_count    <= cnt_sum;
      fin_r.protocol_word <= in_proto_r;
    end
  end

  assign fin_valid = fin_v_r;
  assign fin_word  = fin_r;

endmodule

// ===== src/icph_final.sv =====
// Pseudo-header terms, zero adjustment, complement and result register.
// Depends on icph_pkg and icph_out_if.
module icph_final (
  input  logic           clk,
  input  logic           rst_n,
  input  icph_pkg::cfg_t cfg,
  input  logic           fin_valid,
  input  icph_pkg::fin_t fin_word,
  output logic           fin_ready,
  icph_out_if.source     out_ch
);
  import icph_pkg::*;

  logic        out_v_r, out_v_nxt;
  logic [15:0] chk_r;
  logic [15:0] s_proto;
  logic [15:0] s_len;
  logic [15:0] s_adj;

  assign fin_ready = !out_v_r || out_ch.ready;

  assign s_proto = cfg.pseudo_enable ? oc_add(fin_word.sum, fin_word.protocol_word)
                                     : fin_word.sum;
  assign s_len   = cfg.pseudo_enable ? oc_add(s_proto, fin_word.byte_count) : s_proto;
  // Adding 0xffff end-around leaves a nonzero value as is and maps zero to 0xffff.
  assign s_adj   = (cfg.zero_adjust && s_len == 16'h0000) ? 16'hffff : s_len;

  assign out_v_nxt = fin_ready ? fin_valid : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && fin_valid) begin
      chk_r <= ~s_adj;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.checksum = chk_r;

endmodule

// ===== src/internet_checksum_pseudo_header_unit.sv =====
// Internet checksum (RFC 1071) over a byte stream with optional pseudo-header
// and RFC 1624 terms. Depends on icph_pkg, the channel interfaces,
// icph_accum and icph_final.
//
// Usage:
//   in_ch  : one byte per word (func, data_byte, last, protocol_word).
//   out_ch : one checksum word per packet, after the byte flagged last.
//   cfg_ch : register writes (0 pseudo_enable, 1 zero_adjust); bit 0 of data
//            is used, other indexes are dropped. Always ready. Write only
//            while no packet is in flight.
// Throughput: one byte per cycle, back to back across packets, unless a final
//   byte waits (see Stall). Path: the last byte goes from the input register
//   via the totals register to the result register, which holds the checksum.
// Per-byte loops: the accumulator end-around carry add, byte counter, odd flags.
// Reset clears all packet state, sets pseudo_enable=0, zero_adjust=1.
// Stall: a held result keeps its value; non-final bytes keep flowing, and a
//   final byte waits only while both the totals and result registers are full.
module internet_checksum_pseudo_header_unit (
  input  logic       clk,
  input  logic       rst_n,
  icph_in_if.sink    in_ch,
  icph_out_if.source out_ch,
  icph_cfg_if.sink   cfg_ch
);
  import icph_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic fin_valid;
  logic fin_ready;
  fin_t fin_word;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_PSEUDO_ENABLE: cfg_nxt.pseudo_enable = cfg_ch.data[0];
        REG_ZERO_ADJUST:   cfg_nxt.zero_adjust   = cfg_ch.data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pseudo_enable <= 1'b0;
      cfg_r.zero_adjust   <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  icph_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .fin_valid (fin_valid),
    .fin_word  (fin_word),
    .fin_ready (fin_ready)
  );

  icph_final u_final (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .fin_valid (fin_valid),
    .fin_word  (fin_word),
    .fin_ready (fin_ready),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid && !fin_valid)
    else $error("pipeline not empty after reset");

  a_totals_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid && !fin_ready |=> fin_valid && $stable(fin_word))
    else $error("packet totals lost while result stage stalled");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(fin_valid))
    else $error("result appeared without packet totals");
`endif

endmodule
